[sv/hcbp_pkg.sv]
// shared types and constants for the huffman code bit packer
// no dependencies; used by every module of the block
`default_nettype none

package hcbp_pkg;

   localparam int MAX_CODE_BITS = 16;
   localparam int SYMBOL_COUNT  = 256;

   localparam int CODE_BITS  = 16;
   localparam int LEN_BITS   = 5;
   localparam int SYM_BITS   = 8;
   localparam int BYTE_BITS  = 8;
   localparam int PAD_BITS   = 4;
   localparam int CNT_BITS   = 3;
   localparam int TOTAL_BITS = 5;
   localparam int ACC_BITS   = 24;

   localparam int MAX_LEN = (MAX_CODE_BITS < CODE_BITS) ? MAX_CODE_BITS : CODE_BITS;
   localparam int IDX_BITS = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

   // queue depths, powers of two
   localparam int CMD_DEPTH  = 4;
   localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
   localparam int OUT_DEPTH  = 4;
   localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2
   } op_type;

   typedef struct packed {
      logic                 flush;
      logic [CODE_BITS-1:0] code;
      logic [LEN_BITS-1:0]  len;
   } cmd_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic [PAD_BITS-1:0]  pad_bits;
      logic                 last;
   } rsp_type;

endpackage

`default_nettype wire

[sv/hcbp_front.sv]
// front part: code table, request classification and table lookup stage
// depends on hcbp_pkg
`default_nettype none

module hcbp_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic [1:0]                     req_operation,
   input  wire logic [hcbp_pkg::SYM_BITS-1:0]  req_symbol,
   input  wire logic [hcbp_pkg::CODE_BITS-1:0] req_code_word,
   input  wire logic [hcbp_pkg::LEN_BITS-1:0]  req_code_length,
   output logic                                cmd_push,
   output hcbp_pkg::cmd_type                   cmd_data,
   input  wire logic                           cmd_full
);

   logic [hcbp_pkg::CODE_BITS-1:0] code_mem [hcbp_pkg::SYMBOL_COUNT];
   logic [hcbp_pkg::LEN_BITS-1:0]  len_mem  [hcbp_pkg::SYMBOL_COUNT];

   logic                           stage_valid_ff, stage_valid_in;
   logic                           stage_flush_ff;
   logic                           stage_hit_ff;
   logic [hcbp_pkg::CODE_BITS-1:0] code_rd_ff;
   logic [hcbp_pkg::LEN_BITS-1:0]  len_rd_ff;

   logic                           accept;
   logic                           in_range;
   logic                           is_load, is_encode, is_flush;
   logic [hcbp_pkg::IDX_BITS-1:0]  idx;
   logic [hcbp_pkg::LEN_BITS-1:0]  len_sat;
   logic [hcbp_pkg::CODE_BITS-1:0] code_mask;

   assign req_full  = stage_valid_ff && cmd_full;
   assign accept    = req_push && !req_full;
   assign is_load   = (req_operation == hcbp_pkg::OP_LOAD);
   assign is_encode = (req_operation == hcbp_pkg::OP_ENCODE);
   assign is_flush  = (req_operation == hcbp_pkg::OP_FLUSH);
   assign in_range  = ({1'b0, req_symbol} < 9'(hcbp_pkg::SYMBOL_COUNT));
   assign idx       = req_symbol[hcbp_pkg::IDX_BITS-1:0];

   always_comb begin
      if (req_code_length > hcbp_pkg::LEN_BITS'(hcbp_pkg::MAX_LEN)) begin
         len_sat = hcbp_pkg::LEN_BITS'(hcbp_pkg::MAX_LEN);
      end else begin
         len_sat = req_code_length;
      end
      for (int i = 0; i < hcbp_pkg::CODE_BITS; i++) begin
         code_mask[i] = (hcbp_pkg::LEN_BITS'(i) < len_sat);
      end
   end

   // table write on load, registered read on encode
   always_ff @(posedge clock) begin
      if (accept && is_load && in_range) begin
         code_mem[idx] <= req_code_word & code_mask;
         len_mem[idx]  <= len_sat;
      end
      if (accept && is_encode) begin
         code_rd_ff <= code_mem[idx];
         len_rd_ff  <= len_mem[idx];
      end
   end

   always_comb begin
      if (req_full) begin
         stage_valid_in = stage_valid_ff;
      end else begin
         stage_valid_in = accept && (is_encode || is_flush);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_flush_ff <= is_flush;
         stage_hit_ff   <= is_encode && in_range;
      end
   end

   assign cmd_push = stage_valid_ff && !cmd_full;

   always_comb begin
      cmd_data.flush = stage_flush_ff;
      if (stage_hit_ff) begin
         cmd_data.code = code_rd_ff;
         cmd_data.len  = len_rd_ff;
      end else begin
         cmd_data.code = '0;
         cmd_data.len  = '0;
      end
   end

endmodule

`default_nettype wire

[sv/hcbp_cmd_queue.sv]
// short command queue between the front and back parts
// depends on hcbp_pkg
`default_nettype none

module hcbp_cmd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire hcbp_pkg::cmd_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output hcbp_pkg::cmd_type      pop_data,
   output logic                   empty
);

   hcbp_pkg::cmd_type entry_ff [hcbp_pkg::CMD_DEPTH];

   logic [hcbp_pkg::CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [hcbp_pkg::CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [hcbp_pkg::CMD_CNT_W-1:0] count_ff, count_in;
   logic                           do_push, do_pop;

   assign full     = (count_ff == hcbp_pkg::CMD_CNT_W'(hcbp_pkg::CMD_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? hcbp_pkg::CMD_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? hcbp_pkg::CMD_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + hcbp_pkg::CMD_CNT_W'(do_push)
                  - hcbp_pkg::CMD_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[sv/hcbp_back.sv]
// back part: pending bit state, byte packing and result queue
// depends on hcbp_pkg
`default_nettype none

module hcbp_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire hcbp_pkg::cmd_type              cmd_data,
   input  wire logic                           cmd_empty,
   output logic                                cmd_pop,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic [hcbp_pkg::BYTE_BITS-1:0]      rsp_out_byte,
   output logic [hcbp_pkg::PAD_BITS-1:0]       rsp_pad_bits,
   output logic                                rsp_last
);

   hcbp_pkg::rsp_type out_ff [hcbp_pkg::OUT_DEPTH];

   logic [hcbp_pkg::BYTE_BITS-1:0]  pend_byte_ff, pend_byte_in;
   logic [hcbp_pkg::CNT_BITS-1:0]   pend_count_ff, pend_count_in;
   logic [hcbp_pkg::OUT_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [hcbp_pkg::OUT_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [hcbp_pkg::OUT_CNT_W-1:0]  count_ff, count_in;

   logic                            room;
   logic                            rd_fire;
   logic [1:0]                      nres;
   logic [hcbp_pkg::TOTAL_BITS-1:0] total;
   logic [hcbp_pkg::TOTAL_BITS-1:0] shamt;
   logic [hcbp_pkg::ACC_BITS-1:0]   acc;
   hcbp_pkg::rsp_type               res0, res1;

   assign room    = (count_ff <= hcbp_pkg::OUT_CNT_W'(hcbp_pkg::OUT_DEPTH - 2));
   assign cmd_pop = !cmd_empty && room;

   assign total = hcbp_pkg::TOTAL_BITS'(pend_count_ff) + cmd_data.len;
   assign shamt = hcbp_pkg::TOTAL_BITS'(hcbp_pkg::ACC_BITS) - total;
   assign acc   = {pend_byte_ff, 16'b0}
                  | (hcbp_pkg::ACC_BITS'(cmd_data.code) << shamt);

   always_comb begin
      nres          = 2'd0;
      pend_byte_in  = pend_byte_ff;
      pend_count_in = pend_count_ff;
      res0          = '{out_byte: acc[23:16], pad_bits: '0, last: 1'b0};
      res1          = '{out_byte: acc[15:8], pad_bits: '0, last: 1'b1};
      if (cmd_pop) begin
         if (cmd_data.flush) begin
            if (pend_count_ff != '0) begin
               nres          = 2'd1;
               res0.out_byte = pend_byte_ff;
               res0.pad_bits = hcbp_pkg::PAD_BITS'(4'd8 - {1'b0, pend_count_ff});
               res0.last     = 1'b1;
               pend_byte_in  = '0;
               pend_count_in = '0;
            end
         end else begin
            nres          = total[4:3];
            res0.last     = (total[4:3] == 2'd1);
            pend_count_in = total[2:0];
            case (total[4:3])
               2'd0:    pend_byte_in = acc[23:16];
               2'd1:    pend_byte_in = acc[15:8];
               default: pend_byte_in = acc[7:0];
            endcase
         end
      end
   end

   // result queue, up to two writes and one read per cycle
   assign rsp_empty    = (count_ff == '0);
   assign rd_fire      = rsp_pop && !rsp_empty;
   assign rsp_out_byte = out_ff[rd_ptr_ff].out_byte;
   assign rsp_pad_bits = out_ff[rd_ptr_ff].pad_bits;
   assign rsp_last     = out_ff[rd_ptr_ff].last;

   always_comb begin
      wr_ptr_in = hcbp_pkg::OUT_PTR_W'(wr_ptr_ff + hcbp_pkg::OUT_PTR_W'(nres));
      rd_ptr_in = rd_fire ? hcbp_pkg::OUT_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + hcbp_pkg::OUT_CNT_W'(nres)
                  - hcbp_pkg::OUT_CNT_W'(rd_fire);
   end

   always_ff @(posedge clock) begin
      if (nres != 2'd0) begin
         out_ff[wr_ptr_ff] <= res0;
      end
      if (nres == 2'd2) begin
         out_ff[hcbp_pkg::OUT_PTR_W'(wr_ptr_ff + 1'b1)] <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_byte_ff  <= '0;
         pend_count_ff <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         pend_byte_ff  <= pend_byte_in;
         pend_count_ff <= pend_count_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

endmodule

`default_nettype wire

[sv/huffman_code_bit_packer.sv]
// top level of the huffman code bit packer: front, command queue, back
// depends on hcbp_pkg, hcbp_front, hcbp_cmd_queue, hcbp_back
//
//   channel   handshake          fields
//   request   req_push/req_full  operation, symbol, code_word, code_length
//   response  rsp_pop/rsp_empty  out_byte, pad_bits, last
//
// one request accepted per cycle while the queues have room; an encode can
// yield two bytes on the one-byte response side, so the result queue's single
// read port can limit the encode rate. a result passes the lookup stage
// register, the command queue and the result queue before it is visible; the
// code table is written on the load's accept edge, read into a register on the
// encode's. synchronous reset clears the pending bits and queues, not the table.
`default_nettype none

module huffman_code_bit_packer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic [1:0]                     req_operation,
   input  wire logic [hcbp_pkg::SYM_BITS-1:0]  req_symbol,
   input  wire logic [hcbp_pkg::CODE_BITS-1:0] req_code_word,
   input  wire logic [hcbp_pkg::LEN_BITS-1:0]  req_code_length,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic [hcbp_pkg::BYTE_BITS-1:0]      rsp_out_byte,
   output logic [hcbp_pkg::PAD_BITS-1:0]       rsp_pad_bits,
   output logic                                rsp_last
);

   logic              cmd_push;
   logic              cmd_full;
   logic              cmd_pop;
   logic              cmd_empty;
   hcbp_pkg::cmd_type cmd_in;
   hcbp_pkg::cmd_type cmd_out;

   hcbp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_operation   (req_operation),
      .req_symbol      (req_symbol),
      .req_code_word   (req_code_word),
      .req_code_length (req_code_length),
      .cmd_push        (cmd_push),
      .cmd_data        (cmd_in),
      .cmd_full        (cmd_full)
   );

   hcbp_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .empty     (cmd_empty)
   );

   hcbp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_data     (cmd_out),
      .cmd_empty    (cmd_empty),
      .cmd_pop      (cmd_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_pad_bits (rsp_pad_bits),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire
